/* hdl/wcqs_pkg.sv */
// Package for the weighted class queue scheduler: sizes, codes, shared types
// and the entry address function. Depends on nothing; used by every module in hdl.
package wcqs_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CLASS_COUNT = 5;
  localparam int QUOTA_REGS  = 5;

  localparam int CLS_W   = 3;
  localparam int ACCT_W  = 24;
  localparam int OPS_W   = 8;
  localparam int QUOTA_W = 8;
  localparam int SVC_W   = 16;
  localparam int WAIT_W  = 9;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 8;
  localparam int WORD_W  = ACCT_W + OPS_W;

  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = CLASS_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_TIME_PER_OP = CFG_IDX_W'(QUOTA_REGS);
  localparam logic [QUOTA_W-1:0]   SERVED_MAX      = {QUOTA_W{1'b1}};

  typedef logic [CLS_W-1:0]   cls_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [QUOTA_W-1:0] quota_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Turn state handed to the class picker.
  typedef struct packed {
    cls_t   cur;
    quota_t served;
    quota_t quota;
  } pick_req_t;

  // Picker decision: class to serve and whether a new turn begins there.
  typedef struct packed {
    cls_t cls;
    logic new_turn;
  } pick_t;

  function automatic addr_t entry_addr(cls_t cls, ptr_t ptr);
    entry_addr = ADDR_W'(cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
  endfunction

  function automatic ptr_t ptr_advance(ptr_t ptr);
    ptr_advance = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

endpackage

/* hdl/weighted_class_queue_scheduler_unit.sv */
// Top level of the weighted class queue scheduler: class FIFOs in one entry
// memory, weighted round robin service. Depends on wcqs_pkg and wcqs_pick.
//
// An enqueue or a serve of empty queues gives its result in the cycle after the
// start transaction; a serve that pops an entry passes through the read state first.
// One enqueue per cycle while no pop is in progress; a pop holds busy high in the
// read state while the entry memory data comes back, so no command is taken then.
// Reset (synchronous, rst high) empties all queues, restarts the turn at class 0
// and sets every quota and the time per operation to one. The entry memory keeps
// its contents and needs no clearing pass. The receiver cannot stall results.
module weighted_class_queue_scheduler_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Command channel.
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode,
  input  logic [wcqs_pkg::CLS_W-1:0]      class_in,
  input  logic [wcqs_pkg::ACCT_W-1:0]     account_in,
  input  logic [wcqs_pkg::OPS_W-1:0]      ops_in,
  // Result channel, one transaction per done pulse.
  output logic                            done,
  output logic [wcqs_pkg::STAT_W-1:0]     status,
  output logic [wcqs_pkg::CLS_W-1:0]      class_out,
  output logic [wcqs_pkg::ACCT_W-1:0]     account_out,
  output logic [wcqs_pkg::OPS_W-1:0]      ops_out,
  output logic [wcqs_pkg::SVC_W-1:0]      service_time,
  output logic [wcqs_pkg::WAIT_W-1:0]     waiting_total,
  // Configuration write port.
  input  logic                            cfg_write,
  input  logic [wcqs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcqs_pkg::CFG_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state;

  // Entry memory: account in the upper bits, operation count in the lower bits.
  logic [wcqs_pkg::WORD_W-1:0] store [wcqs_pkg::STORE_DEPTH];
  logic [wcqs_pkg::WORD_W-1:0] rdata;
  logic                        rd_en;
  logic                        wr_en;
  wcqs_pkg::addr_t             rd_addr;
  wcqs_pkg::addr_t             wr_addr;

  // Per-class FIFO bookkeeping, small enough to live in flip-flops.
  wcqs_pkg::ptr_t head [wcqs_pkg::CLASS_COUNT];
  wcqs_pkg::ptr_t tail [wcqs_pkg::CLASS_COUNT];
  wcqs_pkg::cnt_t count [wcqs_pkg::CLASS_COUNT];

  wcqs_pkg::cls_t   current_class;
  wcqs_pkg::quota_t served_in_turn;
  wcqs_pkg::quota_t quota [wcqs_pkg::QUOTA_REGS];
  logic [wcqs_pkg::CFG_W-1:0] time_per_op;
  logic [wcqs_pkg::WAIT_W-1:0] total;

  logic [wcqs_pkg::CLASS_COUNT-1:0] nonempty;
  logic                             any_waiting;
  logic                             accept;
  logic                             cls_bad;
  logic                             enq_reject;
  wcqs_pkg::pick_req_t              pick_req;
  wcqs_pkg::pick_t                  pick;
  wcqs_pkg::quota_t                 served_base;
  wcqs_pkg::quota_t                 served_next;

  assign busy   = (state == ST_READ);
  assign accept = start && !busy;

  always_comb begin
    for (int c = 0; c < wcqs_pkg::CLASS_COUNT; c++) begin
      nonempty[c] = (count[c] != '0);
    end
  end
  assign any_waiting = |nonempty;

  // An enqueue to a class that does not exist, or to a full queue, is refused
  // and leaves every queue as it was.
  assign cls_bad    = (int'(class_in) >= wcqs_pkg::CLASS_COUNT);
  assign enq_reject = cls_bad ? 1'b1
                    : (count[class_in] == wcqs_pkg::CNT_W'(wcqs_pkg::QUEUE_DEPTH));

  // Classes without a quota register keep a quota of one.
  assign pick_req.cur    = current_class;
  assign pick_req.served = served_in_turn;
  assign pick_req.quota  = (int'(current_class) < wcqs_pkg::QUOTA_REGS)
                         ? quota[current_class] : wcqs_pkg::QUOTA_W'(1);

  wcqs_pick u_pick (
    .req      (pick_req),
    .nonempty (nonempty),
    .pick     (pick)
  );

  // A new turn starts from zero; the served counter saturates.
  assign served_base = pick.new_turn ? '0 : served_in_turn;
  assign served_next = (served_base == wcqs_pkg::SERVED_MAX)
                     ? served_base : served_base + wcqs_pkg::QUOTA_W'(1);

  assign wr_en   = accept && !mode && !enq_reject;
  assign wr_addr = wcqs_pkg::entry_addr(class_in, tail[class_in]);
  assign rd_en   = accept && mode && any_waiting;
  assign rd_addr = wcqs_pkg::entry_addr(pick.cls, head[pick.cls]);

  // The memory is never read and written in the same cycle: a pop holds busy
  // high while its data comes back, so no transaction can overlap it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= {account_in, ops_in};
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < wcqs_pkg::CLASS_COUNT; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        count[c] <= '0;
      end
      for (int q = 0; q < wcqs_pkg::QUOTA_REGS; q++) begin
        quota[q] <= wcqs_pkg::QUOTA_W'(1);
      end
      time_per_op    <= wcqs_pkg::CFG_W'(1);
      current_class  <= '0;
      served_in_turn <= '0;
      total          <= '0;
      state          <= ST_IDLE;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        if (int'(cfg_index) < wcqs_pkg::QUOTA_REGS) begin
          quota[cfg_index] <= cfg_data;
        end else if (cfg_index == wcqs_pkg::REG_TIME_PER_OP) begin
          time_per_op <= cfg_data;
        end
      end

      case (state)
        ST_IDLE: begin
          if (accept && !mode) begin
            // Enqueue: the result is ready in the next cycle.
            done <= 1'b1;
            if (!enq_reject) begin
              tail[class_in]  <= wcqs_pkg::ptr_advance(tail[class_in]);
              count[class_in] <= count[class_in] + wcqs_pkg::CNT_W'(1);
              total           <= total + wcqs_pkg::WAIT_W'(1);
            end
          end else if (accept && mode) begin
            if (!any_waiting) begin
              done <= 1'b1;
            end else begin
              // Pop: bookkeeping is updated now, the entry arrives next cycle.
              head[pick.cls]  <= wcqs_pkg::ptr_advance(head[pick.cls]);
              count[pick.cls] <= count[pick.cls] - wcqs_pkg::CNT_W'(1);
              total           <= total - wcqs_pkg::WAIT_W'(1);
              current_class   <= pick.cls;
              served_in_turn  <= served_next;
              state           <= ST_READ;
            end
          end
        end
        ST_READ: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload. The class and the waiting total of a pop are captured at the
  // start transaction; the entry fields follow when the memory data is back.
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      status       <= wcqs_pkg::STAT_OK;
      account_out  <= rdata[wcqs_pkg::WORD_W-1:wcqs_pkg::OPS_W];
      ops_out      <= rdata[wcqs_pkg::OPS_W-1:0];
      service_time <= rdata[wcqs_pkg::OPS_W-1:0] * time_per_op;
    end else if (accept && !mode) begin
      status        <= enq_reject ? wcqs_pkg::STAT_FULL : wcqs_pkg::STAT_OK;
      class_out     <= '0;
      account_out   <= '0;
      ops_out       <= '0;
      service_time  <= '0;
      waiting_total <= enq_reject ? total : total + wcqs_pkg::WAIT_W'(1);
    end else if (accept && mode) begin
      status        <= wcqs_pkg::STAT_EMPTY;
      class_out     <= any_waiting ? pick.cls : '0;
      account_out   <= '0;
      ops_out       <= '0;
      service_time  <= '0;
      waiting_total <= any_waiting ? total - wcqs_pkg::WAIT_W'(1) : total;
    end
  end

  // A pop of a non-empty set of queues always enters the read cycle.
  a_pop_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && mode && any_waiting) |=> busy)
    else $error("pop did not enter the memory read cycle");

  // The read state always returns to idle and ends in a result.
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("memory read cycle did not deliver its result");

  // Every result stems from a start transaction or a read cycle just before.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst)) |-> ($past(accept) || $past(busy)))
    else $error("result strobe without a cause");

endmodule

/* hdl/wcqs_pick.sv */
// Class picker of the weighted class queue scheduler: decides whether the current
// turn ends and finds the next non-empty class. Depends on wcqs_pkg.
module wcqs_pick (
  input  wcqs_pkg::pick_req_t               req,
  input  logic [wcqs_pkg::CLASS_COUNT-1:0]  nonempty,
  output wcqs_pkg::pick_t                   pick
);

  logic                 move;
  wcqs_pkg::cls_t       found;
  logic [wcqs_pkg::CLS_W:0] sum;

  assign move = (req.served >= req.quota) || !nonempty[req.cur];

  // Candidates are visited from the farthest to the nearest, so the nearest
  // non-empty class following the current one wins. The search wraps fully
  // round to the current class itself.
  always_comb begin
    found = req.cur;
    sum   = '0;
    for (int k = wcqs_pkg::CLASS_COUNT; k >= 1; k--) begin
      sum = {1'b0, req.cur} + (wcqs_pkg::CLS_W + 1)'(k);
      if (sum >= (wcqs_pkg::CLS_W + 1)'(wcqs_pkg::CLASS_COUNT)) begin
        sum = sum - (wcqs_pkg::CLS_W + 1)'(wcqs_pkg::CLASS_COUNT);
      end
      if (nonempty[sum[wcqs_pkg::CLS_W-1:0]]) begin
        found = sum[wcqs_pkg::CLS_W-1:0];
      end
    end
  end

  assign pick.cls      = move ? found : req.cur;
  assign pick.new_turn = move;

endmodule

/* dv/weighted_class_queue_scheduler_unit_tb.sv */
// Self-checking testbench for weighted_class_queue_scheduler_unit: directed and random
// enqueue and serve commands, checked against a weighted round robin predictor.
// Depends on wcqs_pkg and the scheduler RTL in hdl; needs nothing else.
`timescale 1ns / 1ps

module weighted_class_queue_scheduler_unit_tb;
  import wcqs_pkg::*;

  // Command codes on the mode input.
  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_SERVE   = 1'b1;

  // Register indexes: the quotas sit at 0..4, the time per operation after them.
  // Index 7 has no register behind it and must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_QUOTA_BASE = '0;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;

  localparam int IDLE_PCT       = 29;
  localparam int ITEMS_PER_PASS = 100;
  localparam int PASS_COUNT     = 6;
  localparam int CYCLE_LIMIT    = 200000;

  // One expected result transaction.
  typedef struct packed {
    status_t                st;
    cls_t                   cls;
    logic [ACCT_W-1:0]      acct;
    logic [OPS_W-1:0]       ops;
    logic [SVC_W-1:0]       svc;
    logic [WAIT_W-1:0]      waiting;
  } outcome_t;

  // Predicts the scheduler from its own copy of the queues and registers and
  // holds the outcomes still to be seen on the result port.
  class wrr_scoreboard;
    logic [WORD_W-1:0] store [CLASS_COUNT][QUEUE_DEPTH];
    int unsigned       head [CLASS_COUNT];
    int unsigned       tail [CLASS_COUNT];
    int unsigned       count [CLASS_COUNT];
    int unsigned       turn_cls;
    int unsigned       served;
    quota_t            quota [CLASS_COUNT];
    logic [CFG_W-1:0]  time_per_op;
    outcome_t          outcomes_due [$];
    int                errors;

    function new();
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head[c]  = 0;
        tail[c]  = 0;
        count[c] = 0;
        quota[c] = 1;
      end
      turn_cls    = 0;
      served      = 0;
      time_per_op = 1;
      errors      = 0;
    endfunction

    function int unsigned clients_waiting();
      int unsigned sum;
      sum = 0;
      for (int c = 0; c < CLASS_COUNT; c++) sum += count[c];
      return sum;
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx < QUOTA_REGS) begin
        quota[idx] = data;
      end else if (idx == REG_TIME_PER_OP) begin
        time_per_op = data;
      end
    endfunction

    // Called for every accepted command transaction.
    function void note_command(logic m, cls_t c, logic [ACCT_W-1:0] a, logic [OPS_W-1:0] o);
      outcome_t          r;
      int unsigned       cur;
      bit                found;
      logic [WORD_W-1:0] word;
      r    = '0;
      r.st = STAT_OK;
      if (m == MODE_ENQUEUE) begin
        if (c >= CLASS_COUNT || count[c] >= QUEUE_DEPTH) begin
          r.st = STAT_FULL;
        end else begin
          store[c][tail[c]] = {a, o};
          tail[c] = (tail[c] + 1) % QUEUE_DEPTH;
          count[c]++;
        end
      end else if (clients_waiting() == 0) begin
        r.st = STAT_EMPTY;
      end else begin
        cur = turn_cls;
        if (served >= quota[cur] || count[cur] == 0) begin
          // The search may come all the way round to the same class, which
          // then starts a fresh turn.
          found = 1'b0;
          for (int k = 1; k <= CLASS_COUNT; k++) begin
            if (!found && count[(turn_cls + k) % CLASS_COUNT] != 0) begin
              cur   = (turn_cls + k) % CLASS_COUNT;
              found = 1'b1;
            end
          end
          served = 0;
        end
        turn_cls = cur;
        word = store[cur][head[cur]];
        head[cur] = (head[cur] + 1) % QUEUE_DEPTH;
        count[cur]--;
        if (served < SERVED_MAX) served++;
        r.cls  = cls_t'(cur);
        r.acct = word[WORD_W-1:OPS_W];
        r.ops  = word[OPS_W-1:0];
        r.svc  = SVC_W'(word[OPS_W-1:0]) * SVC_W'(time_per_op);
      end
      r.waiting = WAIT_W'(clients_waiting());
      outcomes_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Called for every result transaction seen on the done strobe.
    function void check_result(logic [STAT_W-1:0] st, cls_t c, logic [ACCT_W-1:0] a,
                               logic [OPS_W-1:0] o, logic [SVC_W-1:0] svc,
                               logic [WAIT_W-1:0] waiting);
      outcome_t r;
      if (outcomes_due.size() == 0) begin
        $error("result transaction with no command outstanding");
        errors++;
        return;
      end
      r = outcomes_due.pop_front();
      compare_field("status", r.st, st);
      compare_field("class_out", r.cls, c);
      compare_field("account_out", r.acct, a);
      compare_field("ops_out", r.ops, o);
      compare_field("service_time", r.svc, svc);
      compare_field("waiting_total", r.waiting, waiting);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 mode;
  logic [CLS_W-1:0]     class_in;
  logic [ACCT_W-1:0]    account_in;
  logic [OPS_W-1:0]     ops_in;
  logic                 done;
  logic [STAT_W-1:0]    status;
  logic [CLS_W-1:0]     class_out;
  logic [ACCT_W-1:0]    account_out;
  logic [OPS_W-1:0]     ops_out;
  logic [SVC_W-1:0]     service_time;
  logic [WAIT_W-1:0]    waiting_total;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  wrr_scoreboard sb;
  bit            allow_idle = 1'b1;
  int            cycle_count = 0;

  weighted_class_queue_scheduler_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .class_in     (class_in),
    .account_in   (account_in),
    .ops_in       (ops_in),
    .done         (done),
    .status       (status),
    .class_out    (class_out),
    .account_out  (account_out),
    .ops_out      (ops_out),
    .service_time (service_time),
    .waiting_total(waiting_total),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock, low for the first half period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result monitor. The receiver cannot stall the block, so every done pulse is
  // a complete result transaction and is checked at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(status, class_out, account_out, ops_out, service_time, waiting_total);
    end
  end

  // Presents one command at the falling edge, optionally after a random gap, and
  // holds it until a rising edge sees start high with busy low. The command is
  // left on the port on return; the next call or the drain lowers start, so start
  // is assigned at most once per falling edge.
  task automatic send_command(input logic m, input cls_t c, input logic [ACCT_W-1:0] a,
                              input logic [OPS_W-1:0] o);
    @(negedge clk);
    while (allow_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      start = 1'b0;
      @(negedge clk);
    end
    start      = 1'b1;
    mode       = m;
    class_in   = c;
    account_in = a;
    ops_in     = o;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_command(m, c, a, o);
  endtask

  // Lowers start and waits for every outstanding result; the block is idle after.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register write; only ever called with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Writes every register. Mode 0 sets everything to one, mode 1 everything to
  // 255, and otherwise the quotas are mostly small so that the rotation between
  // classes is exercised, with the occasional large one.
  task automatic set_weights(input int pass_mode);
    logic [CFG_W-1:0] v;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      case (pass_mode)
        0: v = 8'd1;
        1: v = 8'd255;
        default: v = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1, 255))
                                                 : CFG_W'($urandom_range(1, 4));
      endcase
      write_reg(REG_QUOTA_BASE + CFG_IDX_W'(c), v);
    end
    case (pass_mode)
      0: v = 8'd1;
      1: v = 8'd255;
      default: v = CFG_W'($urandom_range(1, 255));
    endcase
    write_reg(REG_TIME_PER_OP, v);
  endtask

  // One random command. enq_pct sets the share of enqueues; when focus_cls is a
  // valid class most enqueues go there, which drives that queue to full.
  task automatic send_random_item(input int enq_pct, input int focus_cls);
    logic              m;
    cls_t              c;
    logic [ACCT_W-1:0] a;
    logic [OPS_W-1:0]  o;
    m = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_SERVE;
    if ($urandom_range(0, 99) < 8) begin
      c = cls_t'($urandom_range(CLASS_COUNT, 7));
    end else if (focus_cls < CLASS_COUNT && $urandom_range(0, 9) != 0) begin
      c = cls_t'(focus_cls);
    end else begin
      c = cls_t'($urandom_range(0, CLASS_COUNT - 1));
    end
    case ($urandom_range(0, 9))
      0: a = '0;
      1: a = '1;
      default: a = ACCT_W'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0: o = '0;
      1: o = '1;
      default: o = OPS_W'($urandom());
    endcase
    send_command(m, c, a, o);
  endtask

  initial begin
    int enq_share [PASS_COUNT];
    int focus;

    enq_share = '{60, 55, 90, 25, 55, 50};
    rst        = 1'b1;
    start      = 1'b0;
    mode       = MODE_ENQUEUE;
    class_in   = '0;
    account_in = '0;
    ops_in     = '0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    sb = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with the reset weights in force. A serve with every queue
    // empty must report empty and leave the state alone.
    send_command(MODE_SERVE, 3'd0, 24'h0, 8'h0);
    // Extremes of the account and operation fields into class 0.
    send_command(MODE_ENQUEUE, 3'd0, 24'h000000, 8'h00);
    send_command(MODE_ENQUEUE, 3'd0, 24'hFFFFFF, 8'hFF);
    send_command(MODE_ENQUEUE, 3'd0, 24'h5A5A5A, 8'h81);
    // Classes beyond the last queue are rejected as full.
    send_command(MODE_ENQUEUE, 3'd5, 24'h123456, 8'h11);
    send_command(MODE_ENQUEUE, 3'd6, 24'hABCDEF, 8'h22);
    send_command(MODE_ENQUEUE, 3'd7, 24'hFFFFFF, 8'hFF);
    // With a quota of one and only class 0 holding clients, every serve after
    // the first that finds a client wraps round to class 0 and opens a fresh turn there.
    repeat (3) send_command(MODE_SERVE, 3'd7, 24'hFFFFFF, 8'hFF);
    send_command(MODE_SERVE, 3'd0, 24'h0, 8'h0);
    drain_results();

    // Longest service time, and a quota of two on class 1 with other classes
    // waiting, so the turn moves on only after two clients.
    write_reg(REG_TIME_PER_OP, 8'd255);
    write_reg(REG_QUOTA_BASE + CFG_IDX_W'(1), 8'd2);
    send_command(MODE_ENQUEUE, 3'd1, 24'hFFFFFF, 8'hFF);
    send_command(MODE_ENQUEUE, 3'd1, 24'h000001, 8'h01);
    send_command(MODE_ENQUEUE, 3'd1, 24'h800000, 8'h7E);
    send_command(MODE_ENQUEUE, 3'd3, 24'h0F0F0F, 8'h80);
    send_command(MODE_ENQUEUE, 3'd3, 24'hF0F0F0, 8'h00);
    send_command(MODE_ENQUEUE, 3'd4, 24'h7FFFFF, 8'hFE);
    repeat (7) send_command(MODE_SERVE, 3'd0, 24'h0, 8'h0);
    drain_results();

    // Random part in passes with different weights and mixes: all-one weights,
    // all-255 weights, a pass that fills one queue to overflow, a draining pass
    // that hits empty serves, and a pass without any idle cycles.
    for (int p = 0; p < PASS_COUNT; p++) begin
      set_weights(p);
      if (p == 3) write_reg(REG_UNUSED, CFG_W'($urandom()));
      focus      = (p == 2) ? $urandom_range(0, CLASS_COUNT - 1) : CLASS_COUNT;
      allow_idle = (p != 4);
      repeat (ITEMS_PER_PASS) send_random_item(enq_share[p], focus);
      drain_results();
    end

    // Everything has arrived; keep the clock running for any stray result.
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
